@@ sv/osp_pkg.sv @@
package osp_pkg;

  localparam int unsigned MAX_SAMPLES_DEF  = 256;
  localparam int unsigned SAMPLE_WIDTH_DEF = 32;

  localparam int unsigned RES_W    = 32;
  localparam int unsigned PCT_W    = 15;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned NUM_TAPS = 4;

  localparam logic [PCT_W-1:0] PCT_FULL_Q8  = 15'd25600;
  localparam logic [PCT_W-1:0] PCT_RESET_Q8 = 15'd12800;

  // 75 and 25 percent as fractions in units of 1/256
  localparam logic [FRAC_W-1:0] RANK75_MUL  = 8'd192;
  localparam logic [FRAC_W-1:0] RANK25_MUL  = 8'd64;
  localparam logic [FRAC_W-1:0] MEDIAN_FRAC = 8'd128;

  localparam int unsigned PCT_DIVISOR = 100;
  localparam int unsigned DIV_REM_W   = 7;

  typedef struct packed {
    logic ins;
    logic shl;
  } osp_chain_ctl_t;

endpackage

@@ sv/osp_cell.sv @@
module osp_cell import osp_pkg::*; #(
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  osp_chain_ctl_t                 ctl_i,
  input  logic                           occ_i,
  input  logic                           tail_i,
  input  logic signed [SAMPLE_WIDTH-1:0] new_i,
  input  logic                           left_gt_i,
  input  logic signed [SAMPLE_WIDTH-1:0] left_data_i,
  input  logic signed [SAMPLE_WIDTH-1:0] right_data_i,
  output logic signed [SAMPLE_WIDTH-1:0] data_o,
  output logic                           gt_o
);

  logic signed [SAMPLE_WIDTH-1:0] data_q, data_d;

  assign gt_o   = occ_i && (data_q > new_i);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    if (ctl_i.ins) begin
      if (left_gt_i) begin
        data_d = left_data_i;
      end else if (gt_o || tail_i) begin
        data_d = new_i;
      end
    end else if (ctl_i.shl) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

@@ sv/osp_div.sv @@
module osp_div import osp_pkg::*; #(
  parameter int unsigned DIVIDEND_W = 23,
  parameter int unsigned QUOT_W     = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  output logic                  done_o,
  output logic [QUOT_W-1:0]     quot_o
);

  // x / 100 as x * ceil(2^SHIFT / 100) >> SHIFT, exact for any x below 2^DIVIDEND_W
  localparam int unsigned SHIFT   = DIVIDEND_W + DIV_REM_W;
  localparam int unsigned RECIP_W = DIVIDEND_W + 1;
  localparam int unsigned PROD_W  = DIVIDEND_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << SHIFT) + 64'(PCT_DIVISOR) - 64'd1) / 64'(PCT_DIVISOR));

  logic                  load_q, done_q;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [PROD_W-1:0]     prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      load_q <= start_i;
      done_q <= load_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
    end
    if (load_q) begin
      prod_q <= PROD_W'(dvd_q) * PROD_W'(RECIP);
    end
  end

  assign done_o = done_q;
  assign quot_o = prod_q[SHIFT +: QUOT_W];

endmodule

@@ sv/order_statistic_percentile.sv @@
// Batch percentile, median and IQR. Samples enter through start/busy, one per
// cycle while a batch is open, and are inserted in sorted order into a chain of
// MAX_SAMPLES cells. The sample with last_i set closes the batch: busy stays
// high while the rank product is formed, the percentile rank is divided by 100
// with a reciprocal multiply, the chain is shifted out one cell per cycle past
// the capture point and the taps are interpolated, and through one final cycle
// in which the result shows with done_o high. There is no backpressure, so the
// receiver must take it in that cycle. Samples past capacity are dropped and
// reported with overflow_o. Write cfg_wdata_i only while busy is low.
module order_statistic_percentile import osp_pkg::*; #(
  parameter int unsigned MAX_SAMPLES  = MAX_SAMPLES_DEF,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_i,
  input  logic                           cfg_we_i,
  input  logic [PCT_W-1:0]               cfg_wdata_i,
  output logic                           done_o,
  output logic signed [RES_W-1:0]        pct_value_o,
  output logic signed [RES_W-1:0]        median_value_o,
  output logic [RES_W-1:0]               iqr_value_o,
  output logic [$clog2(MAX_SAMPLES+1)-1:0] sample_count_o,
  output logic                           overflow_o
);

  localparam int unsigned SW     = SAMPLE_WIDTH;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
  localparam int unsigned RANK_W = IDX_W + FRAC_W;
  localparam int unsigned PROD_W = PCT_W + IDX_W;
  localparam int unsigned MUL_W  = SW + FRAC_W;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RANK = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_SCAN = 6'b001000,
    ST_CALC = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [PCT_W-1:0] percent_q;
  logic [CNT_W-1:0] count_q;
  logic             dropped_q;
  logic [IDX_W-1:0] k_q;
  logic [2:0]       c_q;

  logic accept, full;
  assign accept = start && !busy;
  assign full   = (count_q == CNT_W'(MAX_SAMPLES));

  // sorting chain
  osp_chain_ctl_t        ctl;
  logic signed [SW-1:0]  cell_data [MAX_SAMPLES];
  logic                  cell_gt   [MAX_SAMPLES];

  assign ctl.ins = accept && !full;
  assign ctl.shl = (state_q == ST_SCAN);

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic                 left_gt, occ, tail;
    logic signed [SW-1:0] left_data, right_data;
    assign occ  = (CNT_W'(i) < count_q);
    assign tail = (CNT_W'(i) == count_q);
    if (i == 0) begin : g_head
      assign left_gt   = 1'b0;
      assign left_data = sample_i;
    end else begin : g_body
      assign left_gt   = cell_gt[i-1];
      assign left_data = cell_data[i-1];
    end
    if (i == MAX_SAMPLES - 1) begin : g_end
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end
    osp_cell #(.SAMPLE_WIDTH(SW)) u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occ_i       (occ),
      .tail_i      (tail),
      .new_i       (sample_i),
      .left_gt_i   (left_gt),
      .left_data_i (left_data),
      .right_data_i(right_data),
      .data_o      (cell_data[i]),
      .gt_o        (cell_gt[i])
    );
  end

  // batch bookkeeping
  logic [CNT_W-1:0] n_q;
  logic             ovf_q;
  logic [IDX_W-1:0] nm1;
  assign nm1 = IDX_W'(n_q - 1'b1);

  // percentile rank divide
  logic [PCT_W-1:0]  pcl;
  logic [PROD_W-1:0] dividend;
  logic              div_done;
  logic [RANK_W-1:0] quot;

  assign pcl      = (percent_q > PCT_FULL_Q8) ? PCT_FULL_Q8 : percent_q;
  assign dividend = PROD_W'(pcl) * PROD_W'(nm1);

  osp_div #(.DIVIDEND_W(PROD_W), .QUOT_W(RANK_W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (state_q == ST_RANK),
    .dividend_i(dividend),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // taps: pct, median, p75, p25
  logic [RANK_W-1:0] rank75, rank25;
  logic [IDX_W-1:0]  lo_d   [NUM_TAPS];
  logic [FRAC_W-1:0] frac_d [NUM_TAPS];

  assign rank75 = RANK_W'(nm1) * RANK_W'(RANK75_MUL);
  assign rank25 = RANK_W'(nm1) * RANK_W'(RANK25_MUL);

  always_comb begin
    logic [RANK_W-1:0] rk [NUM_TAPS];
    rk[0] = quot;
    rk[1] = '0;
    rk[2] = rank75;
    rk[3] = rank25;
    for (int t = 0; t < NUM_TAPS; t++) begin
      if (rk[t][RANK_W-1:FRAC_W] >= nm1) begin
        lo_d[t]   = nm1;
        frac_d[t] = '0;
      end else begin
        lo_d[t]   = rk[t][RANK_W-1:FRAC_W];
        frac_d[t] = rk[t][FRAC_W-1:0];
      end
    end
    if (n_q[0]) begin
      lo_d[1]   = IDX_W'(n_q >> 1);
      frac_d[1] = '0;
    end else begin
      lo_d[1]   = IDX_W'((n_q >> 1) - 1'b1);
      frac_d[1] = MEDIAN_FRAC;
    end
  end

  logic [IDX_W-1:0]     lo_q   [NUM_TAPS];
  logic [FRAC_W-1:0]    frac_q [NUM_TAPS];
  logic signed [SW-1:0] a_q    [NUM_TAPS];
  logic signed [SW-1:0] b_q    [NUM_TAPS];
  logic [MUL_W-1:0]     prod_q;
  logic signed [SW-1:0] ahold_q;
  logic signed [SW-1:0] res_q  [NUM_TAPS];

  logic [SW-1:0] diff, diff_m;
  assign diff   = SW'(b_q[0] - a_q[0]);
  assign diff_m = (frac_q[0] == '0) ? '0 : diff;

  // control
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && last_i) state_d = ST_RANK;
      ST_RANK: state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_SCAN;
      ST_SCAN: if (k_q == nm1) state_d = ST_CALC;
      ST_CALC: if (c_q == 3'(NUM_TAPS)) state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      percent_q <= PCT_RESET_Q8;
      count_q   <= '0;
      dropped_q <= 1'b0;
      k_q       <= '0;
      c_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        percent_q <= cfg_wdata_i;
      end
      if (accept) begin
        if (last_i) begin
          count_q   <= '0;
          dropped_q <= 1'b0;
        end else if (full) begin
          dropped_q <= 1'b1;
        end else begin
          count_q <= count_q + 1'b1;
        end
      end
      k_q <= (state_q == ST_SCAN) ? k_q + 1'b1 : '0;
      c_q <= (state_q == ST_CALC) ? c_q + 1'b1 : '0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept && last_i) begin
      n_q   <= full ? count_q : count_q + 1'b1;
      ovf_q <= dropped_q || full;
    end
    if (state_q == ST_DIV && div_done) begin
      lo_q   <= lo_d;
      frac_q <= frac_d;
    end
    if (state_q == ST_SCAN) begin
      for (int t = 0; t < NUM_TAPS; t++) begin
        if (k_q == lo_q[t]) begin
          a_q[t] <= cell_data[0];
        end
        if (CNT_W'(k_q) == CNT_W'(lo_q[t]) + 1'b1) begin
          b_q[t] <= cell_data[0];
        end
      end
    end
    if (state_q == ST_CALC) begin
      if (c_q < 3'(NUM_TAPS)) begin
        prod_q  <= MUL_W'(frac_q[0]) * MUL_W'(diff_m);
        ahold_q <= a_q[0];
        for (int t = 0; t < NUM_TAPS - 1; t++) begin
          a_q[t]    <= a_q[t+1];
          b_q[t]    <= b_q[t+1];
          frac_q[t] <= frac_q[t+1];
        end
        a_q[NUM_TAPS-1]    <= a_q[0];
        b_q[NUM_TAPS-1]    <= b_q[0];
        frac_q[NUM_TAPS-1] <= frac_q[0];
      end
      if (c_q != '0) begin
        for (int t = 0; t < NUM_TAPS - 1; t++) begin
          res_q[t] <= res_q[t+1];
        end
        res_q[NUM_TAPS-1] <= ahold_q + $signed(prod_q[MUL_W-1:FRAC_W]);
      end
    end
  end

  // outputs
  logic signed [SW+RES_W-1:0] pct_w, med_w;
  logic [SW-1:0]              iqr_s;
  logic [SW+RES_W-1:0]        iqr_w;

  assign pct_w = (SW+RES_W)'(res_q[0]);
  assign med_w = (SW+RES_W)'(res_q[1]);
  assign iqr_s = SW'(res_q[2] - res_q[3]);
  assign iqr_w = (SW+RES_W)'(iqr_s);

  assign busy           = (state_q != ST_IDLE);
  assign done_o         = (state_q == ST_OUT);
  assign pct_value_o    = pct_w[RES_W-1:0];
  assign median_value_o = med_w[RES_W-1:0];
  assign iqr_value_o    = iqr_w[RES_W-1:0];
  assign sample_count_o = n_q;
  assign overflow_o     = ovf_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> busy)
    else $error("closing transaction did not raise busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !last_i) |=> !busy)
    else $error("open batch blocked next transaction");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (sample_count_o != '0 && sample_count_o <= CNT_W'(MAX_SAMPLES)))
    else $error("sample count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_i) |=> (count_q == '0 && !dropped_q))
    else $error("store not emptied at batch close");

endmodule
